// ===== sv/ipv4tp_pkg.sv =====
// Shared types and constants of the IPv4 text address parser.
// Depends on nothing; used by ipv4tp_step and ipv4_text_address_parser_unit.
`default_nettype none

package ipv4tp_pkg;

  typedef enum logic [2:0] {
    PH_EXPECT = 3'd0,
    PH_ZERO   = 3'd1,
    PH_NUMBER = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic        too_big;
    radix_t      radix;
    logic [1:0]  parts_done;
    logic [7:0]  part0;
    logic [15:0] part1;
    logic [23:0] part2;
  } parser_state_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [2:0]  part_count;
  } parse_result_t;

  localparam parser_state_t STATE_RESET = '{
    phase: PH_EXPECT, acc: 32'd0, too_big: 1'b0, radix: RADIX_DEC,
    parts_done: 2'd0, part0: 8'd0, part1: 16'd0, part2: 24'd0
  };

endpackage

`default_nettype wire

// ===== sv/ipv4tp_step.sv =====
// Next-state and result logic for one character or terminator word.
// Depends on ipv4tp_pkg.
`default_nettype none

module ipv4tp_step
  import ipv4tp_pkg::*;
(
  input  parser_state_t st,
  input  logic [7:0]    ch,
  input  logic          is_end,
  output parser_state_t st_next,
  output parse_result_t res
);

  function automatic parser_state_t number_char(input parser_state_t s,
                                                input logic [7:0] c);
    parser_state_t r;
    logic          is_dec;
    logic          is_hl;
    logic          is_hu;
    logic [3:0]    dval;
    logic [35:0]   prod;
    logic [35:0]   sum;
    r      = s;
    is_dec = (c >= CH_0) && (c <= CH_9);
    is_hl  = (s.radix == RADIX_HEX) && (c >= CH_LA) && (c <= CH_LF);
    is_hu  = (s.radix == RADIX_HEX) && (c >= CH_UA) && (c <= CH_UF);
    if (is_dec) begin
      dval = 4'(c - CH_0);
    end else if (is_hl) begin
      dval = 4'(c - CH_LA + 8'd10);
    end else begin
      dval = 4'(c - CH_UA + 8'd10);
    end
    case (s.radix)
      RADIX_HEX: prod = {s.acc, 4'b0000};
      RADIX_OCT: prod = {1'b0, s.acc, 3'b000};
      default:   prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0};
    endcase
    sum = prod + {32'd0, dval};
    if (is_dec || is_hl || is_hu) begin
      r.acc     = sum[31:0];
      r.too_big = s.too_big | (|sum[35:32]);
      r.phase   = PH_NUMBER;
    end else if (c == CH_DOT) begin
      if (s.parts_done == 2'd3) begin
        r.phase = PH_FAIL;
      end else begin
        case (s.parts_done)
          2'd0:    r.part0 = s.acc[7:0];
          2'd1:    r.part1 = s.acc[15:0];
          default: r.part2 = s.acc[23:0];
        endcase
        r.parts_done = s.parts_done + 2'd1;
        r.acc        = 32'd0;
        r.too_big    = 1'b0;
        r.radix      = RADIX_DEC;
        r.phase      = PH_EXPECT;
      end
    end else if (c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      r.phase = PH_TRAIL;
    end else begin
      r.phase = PH_FAIL;
    end
    return r;
  endfunction

  parser_state_t zs;
  logic [2:0]    n;
  logic          ok;
  logic [31:0]   v;

  always_comb begin
    st_next = st;
    res     = '0;
    zs      = st;
    n       = {1'b0, st.parts_done} + 3'd1;
    ok      = 1'b1;
    v       = st.acc;
    if (!is_end) begin
      unique case (st.phase)
        PH_EXPECT: begin
          if (ch == CH_0) begin
            st_next.acc     = 32'd0;
            st_next.too_big = 1'b0;
            st_next.phase   = PH_ZERO;
          end else if (ch >= CH_1 && ch <= CH_9) begin
            st_next.acc     = {24'd0, ch - CH_0};
            st_next.too_big = 1'b0;
            st_next.radix   = RADIX_DEC;
            st_next.phase   = PH_NUMBER;
          end else begin
            st_next.phase = PH_FAIL;
          end
        end
        PH_ZERO: begin
          if (ch == CH_LX || ch == CH_UX) begin
            st_next.radix = RADIX_HEX;
            st_next.phase = PH_NUMBER;
          end else begin
            zs.radix = RADIX_OCT;
            st_next  = number_char(zs, ch);
          end
        end
        PH_NUMBER: st_next = number_char(st, ch);
        PH_TRAIL:  st_next = st;
        default:   st_next.phase = PH_FAIL;
      endcase
    end else begin
      st_next = STATE_RESET;
      if (st.phase == PH_ZERO || st.phase == PH_NUMBER || st.phase == PH_TRAIL) begin
        case (n)
          3'd2: begin
            ok = !st.too_big && (st.acc[31:24] == 8'd0);
            v  = st.acc | {st.part0, 24'd0};
          end
          3'd3: begin
            ok = !st.too_big && (st.acc[31:16] == 16'd0);
            v  = st.acc | {st.part0, 24'd0} | {st.part1, 16'd0};
          end
          3'd4: begin
            ok = !st.too_big && (st.acc[31:8] == 24'd0);
            v  = st.acc | {st.part0, 24'd0} | {st.part1, 16'd0} | {st.part2, 8'd0};
          end
          default: begin
            ok = 1'b1;
            v  = st.acc;
          end
        endcase
        res.valid_res  = ok;
        res.address    = ok ? v : 32'd0;
        res.part_count = n;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ipv4_text_address_parser_unit.sv =====
// IPv4 text address parser, top level: input register, parse state, result register.
// Depends on ipv4tp_pkg and ipv4tp_step.
//
// Usage:
//   Input channel (char_valid / char_stall) carries one word per character of
//   the address string in ch with is_end low; a word with is_end high ends the
//   string, and ch is ignored on it.
//   Output channel (res_valid / res_stall) carries one result word per
//   terminator: valid_res, address (first part in the top byte, 0 if invalid)
//   and part_count (0 when parsing failed before the final range check).
//   Throughput: one word per cycle on the input channel, no bubbles while the
//   output side keeps up.
//   An accepted terminator passes the input register, then the result register.
//   The parse state is one register set updated by one step of logic per word.
//   Stall: character words keep flowing while a result waits; a terminator
//   waits in the input register until the result register is free, and
//   char_stall rises for that time.
//   Reset: clears both registers' valid flags and returns the parse state to
//   "expect first digit"; after every terminator the parse state restarts too.
`default_nettype none

module ipv4_text_address_parser_unit
  import ipv4tp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  ch,
  input  logic        is_end,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        valid_res,
  output logic [31:0] address,
  output logic [2:0]  part_count
);

  logic          in_full;
  logic [7:0]    in_ch;
  logic          in_end;
  parser_state_t st;
  parser_state_t st_next;
  parse_result_t res_next;
  logic          out_free;
  logic          proc;

  ipv4tp_step u_step (
    .st      (st),
    .ch      (in_ch),
    .is_end  (in_end),
    .st_next (st_next),
    .res     (res_next)
  );

  assign out_free   = !res_valid || !res_stall;
  assign proc       = in_full && (!in_end || out_free);
  assign char_stall = in_full && !proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      res_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (!char_stall) begin
        in_full <= char_valid;
      end
      if (proc) begin
        st <= st_next;
      end
      if (proc && in_end) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_ch  <= ch;
      in_end <= is_end;
    end
    if (proc && in_end) begin
      valid_res  <= res_next.valid_res;
      address    <= res_next.address;
      part_count <= res_next.part_count;
    end
  end

  a_res_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_full && in_end))
    else $error("result word without a terminator");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !valid_res) |-> (address == 32'd0))
    else $error("invalid result carries a nonzero address");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && valid_res) |-> (part_count != 3'd0 && part_count <= 3'd4))
    else $error("valid result with bad part count");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (in_full && in_end && res_valid && res_stall))
    else $error("input stalled without a blocked terminator");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(address)))
    else $error("stalled result word lost or changed");

endmodule

`default_nettype wire

// ===== dv/ipv4_text_address_parser_unit_tb.sv =====
// Testbench for ipv4_text_address_parser_unit: random and directed address strings,
// checked against a cycle-free parse predictor held in a small scoreboard class.
// Depends on ipv4tp_pkg and the RTL of ipv4_text_address_parser_unit.
`default_nettype none

module ipv4_text_address_parser_unit_tb
  import ipv4tp_pkg::*;
;

  localparam int unsigned WORD_TARGET  = 1950;
  localparam int unsigned PAUSE_AT     = 900;
  localparam int unsigned QUIET_AT     = 1650;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef enum int unsigned {FMT_DEC, FMT_OCT, FMT_HEX, FMT_BARE_HEX} part_fmt_t;

  class ipv4_parse_scoreboard;
    phase_t        phase;
    logic [31:0]   acc;
    logic          too_big;
    radix_t        radix;
    logic [1:0]    parts_done;
    logic [23:0]   prior_parts [3];
    parse_result_t pending_addrs [$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_EXPECT;
      acc = '0;
      too_big = 1'b0;
      radix = RADIX_DEC;
      parts_done = '0;
      foreach (prior_parts[i]) prior_parts[i] = '0;
    endfunction

    function int pending();
      return pending_addrs.size();
    endfunction

    function void add_digit(input int unsigned mult, input logic [7:0] d);
      logic [63:0] v;
      v = {32'd0, acc} * 64'(mult) + 64'(d);
      if (v[63:32] != '0) too_big = 1'b1;
      acc = v[31:0];
    endfunction

    function void number_char(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) begin
        add_digit(radix == RADIX_HEX ? 16 : (radix == RADIX_OCT ? 8 : 10), c - CH_0);
        phase = PH_NUMBER;
      end else if (radix == RADIX_HEX && c >= CH_LA && c <= CH_LF) begin
        add_digit(16, c - CH_LA + 8'd10);
        phase = PH_NUMBER;
      end else if (radix == RADIX_HEX && c >= CH_UA && c <= CH_UF) begin
        add_digit(16, c - CH_UA + 8'd10);
        phase = PH_NUMBER;
      end else if (c == CH_DOT) begin
        if (parts_done == 2'd3) begin
          phase = PH_FAIL;
        end else begin
          prior_parts[parts_done] = acc[23:0];
          parts_done++;
          acc = '0;
          too_big = 1'b0;
          radix = RADIX_DEC;
          phase = PH_EXPECT;
        end
      end else if (c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        phase = PH_TRAIL;
      end else begin
        phase = PH_FAIL;
      end
    endfunction

    function void take_char_word(input logic [7:0] c, input logic term);
      parse_result_t r;
      logic [2:0]    n;
      logic [31:0]   v;
      if (!term) begin
        case (phase)
          PH_EXPECT: begin
            if (c == CH_0) begin
              acc = '0;
              too_big = 1'b0;
              phase = PH_ZERO;
            end else if (c >= CH_1 && c <= CH_9) begin
              acc = 32'(c - CH_0);
              too_big = 1'b0;
              radix = RADIX_DEC;
              phase = PH_NUMBER;
            end else begin
              phase = PH_FAIL;
            end
          end
          PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
              radix = RADIX_HEX;
              phase = PH_NUMBER;
            end else begin
              radix = RADIX_OCT;
              number_char(c);
            end
          end
          PH_NUMBER: number_char(c);
          PH_TRAIL: ;
          default: phase = PH_FAIL;
        endcase
        return;
      end
      r = '0;
      if (phase == PH_ZERO || phase == PH_NUMBER || phase == PH_TRAIL) begin
        n = {1'b0, parts_done} + 3'd1;
        v = acc;
        r.part_count = n;
        r.valid_res = 1'b1;
        case (n)
          3'd2: begin
            if (too_big || v > 32'hFF_FFFF) r.valid_res = 1'b0;
            else v |= {prior_parts[0][7:0], 24'd0};
          end
          3'd3: begin
            if (too_big || v > 32'hFFFF) r.valid_res = 1'b0;
            else v |= {prior_parts[0][7:0], 24'd0} | {prior_parts[1][15:0], 16'd0};
          end
          3'd4: begin
            if (too_big || v > 32'hFF) r.valid_res = 1'b0;
            else v |= {prior_parts[0][7:0], 24'd0} | {prior_parts[1][15:0], 16'd0}
                    | {prior_parts[2], 8'd0};
          end
          default: ;
        endcase
        r.address = r.valid_res ? v : 32'd0;
      end
      pending_addrs.push_back(r);
      restart();
    endfunction

    function void check_addr_word(input logic vr, input logic [31:0] a, input logic [2:0] pc);
      parse_result_t e;
      if (pending_addrs.size() == 0) begin
        $display("%0t: unexpected result valid_res=%0d address=%h part_count=%0d",
                 $time, vr, a, pc);
        mismatches++;
        return;
      end
      e = pending_addrs.pop_front();
      if (vr !== e.valid_res) begin
        $display("%0t: valid_res expected %0d actual %0d", $time, e.valid_res, vr);
        mismatches++;
      end
      if (a !== e.address) begin
        $display("%0t: address expected %h actual %h", $time, e.address, a);
        mismatches++;
      end
      if (pc !== e.part_count) begin
        $display("%0t: part_count expected %0d actual %0d", $time, e.part_count, pc);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  logic [7:0]  ch;
  logic        is_end;
  logic        res_valid;
  logic        res_stall;
  logic        valid_res;
  logic [31:0] address;
  logic [2:0]  part_count;

  ipv4_parse_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          paused = 1'b0;

  ipv4_text_address_parser_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ch         (ch),
    .is_end     (is_end),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .valid_res  (valid_res),
    .address    (address),
    .part_count (part_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_addr_word(valid_res, address, part_count);
  end

  initial begin
    int unsigned burst;
    burst = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        res_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
        res_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6) - 1;
        res_stall = 1'b1;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input logic term);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      char_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    char_valid = 1'b1;
    ch = c;
    is_end = term;
    do @(posedge clk); while (char_stall);
    sb.take_char_word(c, term);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic end_string();
    send_word(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && ((c >= CH_LA && c <= CH_LF) || c == CH_LX) && $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      send_word(c, 1'b0);
    end
  endtask

  function automatic logic [63:0] pick_value(input int unsigned bits);
    logic [63:0] mask;
    logic [63:0] r;
    mask = (64'd1 << bits) - 64'd1;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return mask;
      2: return mask + 64'd1;
      3: return (64'd1 << 32) | (r & 64'hFF_FFFF_FFFF);
      4: return r & 64'hFF;
      default: return (r & mask) >> $urandom_range(0, bits - 1);
    endcase
  endfunction

  function automatic string part_text(input logic [63:0] v, input part_fmt_t fmt);
    case (fmt)
      FMT_DEC: return $sformatf("%0d", v);
      FMT_OCT: begin
        if ($urandom_range(0, 5) == 0) return {"0", $sformatf("%0o", v), "9"};
        return {"0", $sformatf("%0o", v)};
      end
      FMT_HEX: return {"0x", $sformatf("%0h", v)};
      default: return "0x";
    endcase
  endfunction

  task automatic send_address(input bit corrupt);
    int unsigned n;
    int unsigned bits;
    int unsigned bad_at;
    part_fmt_t   fmt;
    n = $urandom_range(1, 4);
    bad_at = $urandom_range(0, n - 1);
    for (int p = 0; p < n; p++) begin
      if (p == n - 1) bits = 32 - 8 * (n - 1);
      else bits = ($urandom_range(0, 3) == 0) ? 24 : 8;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: fmt = FMT_DEC;
        4, 5: fmt = FMT_OCT;
        9: fmt = FMT_BARE_HEX;
        default: fmt = FMT_HEX;
      endcase
      if (corrupt && p == bad_at) send_word(8'($urandom), 1'b0);
      send_text(part_text(pick_value(bits), fmt), fmt == FMT_HEX || fmt == FMT_BARE_HEX);
      if (p < n - 1) send_word(CH_DOT, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        5: send_word(CH_SPACE, 1'b0);
        6: send_word(CH_NUL, 1'b0);
        default: send_word(CH_TAB + 8'($urandom_range(0, 4)), 1'b0);
      endcase
      repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0);
    end
    end_string();
  endtask

  task automatic send_noise();
    string       charset;
    logic [7:0]  c;
    charset = "0123456789abcdefxX. \t";
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 2) == 0) c = 8'($urandom);
      else c = charset[$urandom_range(0, charset.len() - 1)];
      send_word(c, 1'b0);
    end
    end_string();
  endtask

  initial begin
    rst = 1'b1;
    char_valid = 1'b0;
    ch = '0;
    is_end = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text("0", 0);                end_string();
    send_text("4294967295", 0);       end_string();
    send_text("4294967296", 0);       end_string();
    send_text("0xfF.0X1a.077.9", 0);  end_string();
    send_text("255.255.255.255", 0);  end_string();
    send_text("1.2.3.256", 0);        end_string();
    send_text("1.2.99999999999", 0);  end_string();
    send_text("300.70000.1", 0);      end_string();
    send_text("0x", 0);               end_string();
    send_text("089", 0);              end_string();
    send_text("1.2.3.4.5", 0);        end_string();
    send_text(".1", 0);               end_string();
    send_text("1..2", 0);             end_string();
    send_text("1.", 0);               end_string();
    end_string();
    send_text("12 ", 0); send_word(8'hFF, 1'b0); send_text("zz", 0); end_string();
    send_text("7", 0); send_word(CH_NUL, 1'b0); send_text("9", 0); end_string();
    send_text("3", 0); send_word(CH_CR, 1'b0); end_string();
    send_word(8'h80, 1'b0);           end_string();
    send_text("1", 0); send_word(8'hFF, 1'b0); end_string();
    send_text("0xg", 0);              end_string();
    send_text("1a", 0);               end_string();

    while (words_sent < WORD_TARGET) begin
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        char_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if (words_sent >= QUIET_AT) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2: send_noise();
        3, 4, 5: send_address(1'b1);
        default: send_address(1'b0);
      endcase
    end
    char_valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ===== ipv4_text_address_parser_unit.f =====
sv/ipv4tp_pkg.sv
sv/ipv4tp_step.sv
sv/ipv4_text_address_parser_unit.sv
dv/ipv4_text_address_parser_unit_tb.sv
